// ===== design/ireu_pkg.sv =====
// ----------------------------------------------------------------------------
// ireu_pkg
// Shared types and constants for the interpreter register execute unit.
// ----------------------------------------------------------------------------
package ireu_pkg;

	localparam int unsigned ADDR_W = 12;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned REG_N  = 16;
	localparam int unsigned REG_W  = $clog2(REG_N);

	localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
	localparam logic [REG_W-1:0]  FLAG_REG = 4'hF;
	localparam logic [REG_W-1:0]  ZERO_REG = 4'h0;

	typedef enum logic [1:0] {
		ST_EXEC      = 2'd0,
		ST_UNHANDLED = 2'd1,
		ST_ILLEGAL   = 2'd2
	} status_t;

	// opcode nibble
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SE   = 4'h3;
	localparam logic [3:0] OP_SNE  = 4'h4;
	localparam logic [3:0] OP_SEV  = 4'h5;
	localparam logic [3:0] OP_LD   = 4'h6;
	localparam logic [3:0] OP_ADD  = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNEV = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPV  = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	// 8xy sub-codes
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// system words
	localparam logic [15:0] W_CLS = 16'h00E0;
	localparam logic [15:0] W_RET = 16'h00EE;

	// E and F group sub-codes
	localparam logic [7:0] KK_SKP    = 8'h9E;
	localparam logic [7:0] KK_SKNP   = 8'hA1;
	localparam logic [7:0] KK_GET_DT = 8'h07;
	localparam logic [7:0] KK_WAITK  = 8'h0A;
	localparam logic [7:0] KK_SET_DT = 8'h15;
	localparam logic [7:0] KK_SET_ST = 8'h18;
	localparam logic [7:0] KK_FONT   = 8'h29;
	localparam logic [7:0] KK_BCD    = 8'h33;
	localparam logic [7:0] KK_STORE  = 8'h55;
	localparam logic [7:0] KK_LOAD   = 8'h65;
	localparam logic [7:0] KK_ADD_I  = 8'h1E;

endpackage

// ===== design/ireu_if.sv =====
// ----------------------------------------------------------------------------
// ireu_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface ireu_instr_if;
	logic        valid;
	logic        ready;
	logic [15:0] instruction_word;
	logic [7:0]  random_byte;

	modport source (output valid, output instruction_word, output random_byte, input ready);
	modport sink   (input valid, input instruction_word, input random_byte, output ready);
endinterface

interface ireu_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] next_pc;
	logic [11:0] index_value;
	logic        dest_written;
	logic [3:0]  dest_index;
	logic [7:0]  dest_value;
	logic        flag_written;
	logic        flag_value;
	logic        skipped;
	logic [1:0]  status;

	modport source (
		output valid, output next_pc, output index_value, output dest_written,
		output dest_index, output dest_value, output flag_written, output flag_value,
		output skipped, output status, input ready
	);
	modport sink (
		input valid, input next_pc, input index_value, input dest_written,
		input dest_index, input dest_value, input flag_written, input flag_value,
		input skipped, input status, output ready
	);
endinterface

// ===== design/interpreter_register_execute_unit.sv =====
// ----------------------------------------------------------------------------
// interpreter_register_execute_unit
// Executes one CHIP-8 style instruction per beat against V0..VF, I and PC.
// ----------------------------------------------------------------------------
// usage:
//   instr  : instruction word plus a random byte, one beat per instruction
//   result : next pc, index, register write, flag write, skip and status
// an instruction beat is captured in the s1 register together with the
// registered reads of Vx and Vy; once the result register can advance, s1
// executes it, commits the architectural state and loads the result register.
// one instruction per cycle is sustained while result.ready stays high.
// the rate is set by the single decode/ALU pass between s1 and the result
// register; a write in the committing cycle is bypassed into the next read.
// reset: V0..VF and I clear to zero, pc starts at 0x200, both stages empty.
// when result.ready is low the result register holds, s1 holds behind it and
// instr.ready drops once s1 is also full; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module interpreter_register_execute_unit (
	input logic           clk,
	input logic           arst_n,
	ireu_instr_if.sink    instr,
	ireu_result_if.source result
);

	localparam int unsigned AW = ireu_pkg::ADDR_W;
	localparam int unsigned BW = ireu_pkg::BYTE_W;
	localparam int unsigned RW = ireu_pkg::REG_W;

	// architectural state
	logic [AW-1:0]           pc_q;
	logic [AW-1:0]           idx_q;
	logic [BW-1:0]           v0_q;
	logic [BW-1:0]           vf_q;
	logic [BW-1:0]           rf_mem [ireu_pkg::REG_N];
	logic [ireu_pkg::REG_N-1:0] rf_vld_q;

	// stage 1
	logic          valid_s1;
	logic [15:0]   word_s1;
	logic [BW-1:0] rnd_s1;
	logic [BW-1:0] rdx_s1;
	logic [BW-1:0] rdy_s1;

	// result register
	logic          out_valid_q;
	logic [AW-1:0] npc_q;
	logic [AW-1:0] oidx_q;
	logic          dw_q;
	logic [RW-1:0] dix_q;
	logic [BW-1:0] dv_q;
	logic          fw_q;
	logic          fv_q;
	logic          skip_q;
	ireu_pkg::status_t st_q;

	logic adv;
	logic commit;
	logic accept;

	assign adv    = !out_valid_q || result.ready;
	assign commit = valid_s1 && adv;
	assign accept = instr.valid && instr.ready;
	assign instr.ready = !valid_s1 || adv;

	// decode
	logic [3:0]    op;
	logic [RW-1:0] x;
	logic [3:0]    n;
	logic [BW-1:0] kk;
	logic [AW-1:0] nnn;
	logic [BW-1:0] vx;
	logic [BW-1:0] vy;

	assign op  = word_s1[15:12];
	assign x   = word_s1[11:8];
	assign n   = word_s1[3:0];
	assign kk  = word_s1[7:0];
	assign nnn = word_s1[11:0];
	assign vx  = (x == ireu_pkg::FLAG_REG) ? vf_q : rdx_s1;
	assign vy  = (word_s1[7:4] == ireu_pkg::FLAG_REG) ? vf_q : rdy_s1;

	logic [AW-1:0] pc_inc2;
	logic [AW-1:0] pc_inc4;
	logic [BW:0]   sum9;
	logic [AW-1:0] npc;
	logic [AW-1:0] idx_n;
	logic          dw;
	logic          fw;
	logic          skip;
	logic [BW-1:0] dv;
	logic          fv;
	ireu_pkg::status_t st;
	logic          dw_f;
	logic          fw_f;
	logic          skip_f;
	logic [AW-1:0] npc_f;
	logic [BW-1:0] dv_f;
	logic          fv_f;

	assign pc_inc2 = pc_q + AW'(2);
	assign pc_inc4 = pc_q + AW'(4);
	assign sum9    = {1'b0, vx} + {1'b0, vy};

	always_comb begin
		st    = ireu_pkg::ST_EXEC;
		dw    = 1'b0;
		fw    = 1'b0;
		skip  = 1'b0;
		dv    = '0;
		fv    = 1'b0;
		npc   = pc_inc2;
		idx_n = idx_q;
		case (op)
			ireu_pkg::OP_SYS: begin
				if (word_s1 == ireu_pkg::W_CLS || word_s1 == ireu_pkg::W_RET)
					st = ireu_pkg::ST_UNHANDLED;
				else
					st = ireu_pkg::ST_ILLEGAL;
			end
			ireu_pkg::OP_JP:   npc = nnn;
			ireu_pkg::OP_CALL: st = ireu_pkg::ST_UNHANDLED;
			ireu_pkg::OP_SE:   skip = (vx == kk);
			ireu_pkg::OP_SNE:  skip = (vx != kk);
			ireu_pkg::OP_SEV: begin
				if (n != 4'h0) st = ireu_pkg::ST_ILLEGAL;
				else skip = (vx == vy);
			end
			ireu_pkg::OP_LD: begin
				dw = 1'b1;
				dv = kk;
			end
			ireu_pkg::OP_ADD: begin
				dw = 1'b1;
				dv = vx + kk;
			end
			ireu_pkg::OP_ALU: begin
				dw = 1'b1;
				case (n)
					ireu_pkg::ALU_MOV: dv = vy;
					ireu_pkg::ALU_OR:  dv = vx | vy;
					ireu_pkg::ALU_AND: dv = vx & vy;
					ireu_pkg::ALU_XOR: dv = vx ^ vy;
					ireu_pkg::ALU_ADD: begin
						dv = sum9[BW-1:0];
						fw = 1'b1;
						fv = sum9[BW];
					end
					ireu_pkg::ALU_SUB: begin
						dv = vx - vy;
						fw = 1'b1;
						fv = (vx >= vy);
					end
					ireu_pkg::ALU_SHR: begin
						dv = {1'b0, vx[BW-1:1]};
						fw = 1'b1;
						fv = vx[0];
					end
					ireu_pkg::ALU_RSB: begin
						dv = vy - vx;
						fw = 1'b1;
						fv = (vy >= vx);
					end
					ireu_pkg::ALU_SHL: begin
						dv = {vx[BW-2:0], 1'b0};
						fw = 1'b1;
						fv = vx[BW-1];
					end
					default: begin
						dw = 1'b0;
						st = ireu_pkg::ST_ILLEGAL;
					end
				endcase
			end
			ireu_pkg::OP_SNEV: begin
				if (n != 4'h0) st = ireu_pkg::ST_ILLEGAL;
				else skip = (vx != vy);
			end
			ireu_pkg::OP_LDI: idx_n = nnn;
			ireu_pkg::OP_JPV: npc = nnn + {{(AW-BW){1'b0}}, v0_q};
			ireu_pkg::OP_RND: begin
				dw = 1'b1;
				dv = rnd_s1 & kk;
			end
			ireu_pkg::OP_DRW: st = ireu_pkg::ST_UNHANDLED;
			ireu_pkg::OP_KEY: begin
				if (kk == ireu_pkg::KK_SKP || kk == ireu_pkg::KK_SKNP)
					st = ireu_pkg::ST_UNHANDLED;
				else
					st = ireu_pkg::ST_ILLEGAL;
			end
			ireu_pkg::OP_MISC: begin
				case (kk)
					ireu_pkg::KK_ADD_I: idx_n = idx_q + {{(AW-BW){1'b0}}, vx};
					ireu_pkg::KK_GET_DT, ireu_pkg::KK_WAITK, ireu_pkg::KK_SET_DT,
					ireu_pkg::KK_SET_ST, ireu_pkg::KK_FONT, ireu_pkg::KK_BCD,
					ireu_pkg::KK_STORE, ireu_pkg::KK_LOAD:
						st = ireu_pkg::ST_UNHANDLED;
					default: st = ireu_pkg::ST_ILLEGAL;
				endcase
			end
			default: st = ireu_pkg::ST_ILLEGAL;
		endcase
	end

	// illegal words leave everything untouched
	always_comb begin
		dw_f   = dw;
		fw_f   = fw;
		skip_f = skip;
		npc_f  = npc;
		if (st == ireu_pkg::ST_ILLEGAL) begin
			dw_f   = 1'b0;
			fw_f   = 1'b0;
			skip_f = 1'b0;
			npc_f  = pc_q;
		end else if (skip) begin
			npc_f  = pc_inc4;
		end
		dv_f = dw_f ? dv : '0;
		fv_f = fw_f & fv;
	end

	// register file write port, VF lives in its own register
	logic          rf_we;
	logic [BW-1:0] rdx_n;
	logic [BW-1:0] rdy_n;
	logic [RW-1:0] x_in;
	logic [RW-1:0] y_in;

	assign rf_we = commit && dw_f && (x != ireu_pkg::FLAG_REG);
	assign x_in  = instr.instruction_word[11:8];
	assign y_in  = instr.instruction_word[7:4];

	always_ff @(posedge clk) begin
		if (rf_we)
			rf_mem[x] <= dv_f;
	end

	// read with write-first bypass of the committing instruction
	always_ff @(posedge clk) begin
		if (accept) begin
			if (rf_we && x == x_in)
				rdx_s1 <= dv_f;
			else
				rdx_s1 <= rf_vld_q[x_in] ? rf_mem[x_in] : '0;
			if (rf_we && x == y_in)
				rdy_s1 <= dv_f;
			else
				rdy_s1 <= rf_vld_q[y_in] ? rf_mem[y_in] : '0;
			word_s1 <= instr.instruction_word;
			rnd_s1  <= instr.random_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q    <= '0;
			pc_q        <= ireu_pkg::PC_RESET;
			idx_q       <= '0;
			v0_q        <= '0;
			vf_q        <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (commit)
				valid_s1 <= 1'b0;
			if (commit)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (commit) begin
				pc_q  <= npc_f;
				idx_q <= idx_n;
				if (rf_we)
					rf_vld_q[x] <= 1'b1;
				if (dw_f && x == ireu_pkg::ZERO_REG)
					v0_q <= dv_f;
				// flag wins over the ALU result when x is VF
				if (fw_f)
					vf_q <= {{(BW-1){1'b0}}, fv_f};
				else if (dw_f && x == ireu_pkg::FLAG_REG)
					vf_q <= dv_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			npc_q  <= npc_f;
			oidx_q <= idx_n;
			dw_q   <= dw_f;
			dix_q  <= dw_f ? x : '0;
			dv_q   <= dv_f;
			fw_q   <= fw_f;
			fv_q   <= fv_f;
			skip_q <= skip_f;
			st_q   <= st;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.next_pc      = npc_q;
	assign result.index_value  = oidx_q;
	assign result.dest_written = dw_q;
	assign result.dest_index   = dix_q;
	assign result.dest_value   = dv_q;
	assign result.flag_written = fw_q;
	assign result.flag_value   = fv_q;
	assign result.skipped      = skip_q;
	assign result.status       = st_q;

	// checks
	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && st_q == ireu_pkg::ST_ILLEGAL |-> !dw_q && !fw_q && !skip_q)
		else $error("illegal instruction reported a side effect");

	a_flag_with_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fw_q |-> dw_q && st_q == ireu_pkg::ST_EXEC)
		else $error("flag write without a register write");

	a_pc_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> npc_q == pc_q && oidx_q == idx_q)
		else $error("result pc or index differs from committed state");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(word_s1) && $stable(rdx_s1))
		else $error("stalled instruction lost in s1");

	a_skip_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && skip_f |-> npc_f == pc_inc4)
		else $error("skip did not advance pc by four");

endmodule
